### rtl/jsu_pkg.sv
// Package for the JSON string unescape unit: modes, request types, decode helpers.
package jsu_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [20:0] CP_SUPP_BASE = 21'h10000;
  localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG = 6'b110111;

  // UTF-8 bytes of U+FFFD
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;
  localparam logic [2:0] REPL_LEN = 3'd3;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX,
    MODE_HELD,
    MODE_HELD_ESC,
    MODE_HEX2
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NO_OPEN,
    ERR_UNTERM,
    ERR_UNTERM_ESC,
    ERR_TRUNC_U,
    ERR_BAD_HEX,
    ERR_UNKNOWN_ESC
  } err_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RAW,
    OP_CP,
    OP_DONE,
    OP_ERR
  } op_t;

  // One request from front to back: optional U+FFFD, then one main action.
  typedef struct packed {
    logic        pre_repl;
    op_t         op;
    logic [20:0] data;
  } cmd_t;

  // {valid, digit}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // {valid, byte}
  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    r = '0;
    unique case (c)
      8'h22: r = {1'b1, 8'h22};
      8'h5C: r = {1'b1, 8'h5C};
      8'h2F: r = {1'b1, 8'h2F};
      8'h62: r = {1'b1, 8'h08};
      8'h66: r = {1'b1, 8'h0C};
      8'h6E: r = {1'b1, 8'h0A};
      8'h72: r = {1'b1, 8'h0D};
      8'h74: r = {1'b1, 8'h09};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/jsu_front.sv
// Front end: accepts input bytes, tracks string/escape state, issues decode requests.
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  held_r, held_nxt;
  cmd_t        cmd;
  logic [4:0]  hx;
  logic [8:0]  es;
  logic [15:0] acc_new;
  logic        new_low, new_high;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hx       = hex_decode(in_byte);
  assign es       = esc_decode(in_byte);
  assign acc_new  = {acc_r[11:0], hx[3:0]};
  assign new_low  = (acc_new[15:10] == SURR_LOW_TAG);
  assign new_high = (acc_new[15:10] == SURR_HIGH_TAG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      cnt_r  <= '0;
      held_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    held_nxt = held_r;
    cmd      = '0;
    cmd.op   = OP_NONE;
    if (in_end_of_text) begin
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      held_nxt = '0;
      cmd.op   = OP_ERR;
      unique case (mode_r)
        MODE_BODY, MODE_HELD:    cmd.data = 21'(ERR_UNTERM);
        MODE_ESC, MODE_HELD_ESC: cmd.data = 21'(ERR_UNTERM_ESC);
        MODE_HEX, MODE_HEX2:     cmd.data = 21'(ERR_TRUNC_U);
        default:                 cmd.data = 21'(ERR_NO_OPEN);
      endcase
    end else begin
      unique case (mode_r)
        MODE_BODY: begin
          if (in_byte == CH_QUOTE) begin
            cmd.op   = OP_DONE;
            mode_nxt = MODE_IDLE;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            held_nxt = '0;
          end else if (in_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            cmd.op   = OP_RAW;
            cmd.data = 21'(in_byte);
          end
        end
        MODE_ESC, MODE_HELD_ESC: begin
          if (in_byte == CH_U) begin
            mode_nxt = (mode_r == MODE_ESC) ? MODE_HEX : MODE_HEX2;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else if (!es[8]) begin
            cmd.op   = OP_ERR;
            cmd.data = 21'(ERR_UNKNOWN_ESC);
            mode_nxt = MODE_IDLE;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            held_nxt = '0;
          end else begin
            cmd.pre_repl = (mode_r == MODE_HELD_ESC);
            cmd.op       = OP_RAW;
            cmd.data     = 21'(es[7:0]);
            held_nxt     = '0;
            mode_nxt     = MODE_BODY;
          end
        end
        MODE_HEX, MODE_HEX2: begin
          if (!hx[4]) begin
            cmd.op   = OP_ERR;
            cmd.data = 21'(ERR_BAD_HEX);
            mode_nxt = MODE_IDLE;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            held_nxt = '0;
          end else if (cnt_r != 2'd3) begin
            acc_nxt = acc_new;
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt = '0;
            acc_nxt = '0;
            if (mode_r == MODE_HEX2 && new_low) begin
              cmd.op   = OP_CP;
              cmd.data = CP_SUPP_BASE + 21'({held_r, acc_new[9:0]});
              held_nxt = '0;
              mode_nxt = MODE_BODY;
            end else begin
              cmd.pre_repl = (mode_r == MODE_HEX2);
              if (new_high) begin
                held_nxt = acc_new[9:0];
                mode_nxt = MODE_HELD;
              end else begin
                held_nxt = '0;
                cmd.op   = OP_CP;
                cmd.data = new_low ? CP_REPLACE : 21'(acc_new);
                mode_nxt = MODE_BODY;
              end
            end
          end
        end
        MODE_HELD: begin
          if (in_byte == CH_BSLASH) begin
            mode_nxt = MODE_HELD_ESC;
          end else begin
            cmd.pre_repl = 1'b1;
            held_nxt     = '0;
            if (in_byte == CH_QUOTE) begin
              cmd.op   = OP_DONE;
              mode_nxt = MODE_IDLE;
              acc_nxt  = '0;
              cnt_nxt  = '0;
            end else begin
              cmd.op   = OP_RAW;
              cmd.data = 21'(in_byte);
              mode_nxt = MODE_BODY;
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          held_nxt = '0;
          if (in_byte == CH_QUOTE) begin
            mode_nxt = MODE_BODY;
          end else begin
            cmd.op   = OP_ERR;
            cmd.data = 21'(ERR_NO_OPEN);
          end
        end
      endcase
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd.pre_repl || cmd.op != OP_NONE);

endmodule

### rtl/jsu_cmdq.sv
// Small request queue between the front end and the byte emitter.
module jsu_cmdq
  import jsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !do_pop) cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

### rtl/jsu_back.sv
// Back end: expands each request into UTF-8 result items through an output register.
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_done,
  output logic       out_error_flag,
  output logic [2:0] out_error_kind,
  output logic       out_last
);

  logic [2:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r, done_r, err_r, last_r;
  logic [2:0] kind_r;

  logic [2:0]  n_pre, n_main, total, j;
  logic [2:0]  cp_len;
  logic [20:0] cp;
  logic [7:0]  cp_byte, e_byte;
  logic        e_bvalid, e_done, e_err, e_last;
  logic [2:0]  e_kind;
  logic        load;

  assign cp = head_cmd.data;

  always_comb begin
    if (cp < 21'h80) cp_len = 3'd1;
    else if (cp < 21'h800) cp_len = 3'd2;
    else if (cp < 21'h10000) cp_len = 3'd3;
    else cp_len = 3'd4;
  end

  assign n_pre = head_cmd.pre_repl ? REPL_LEN : 3'd0;

  always_comb begin
    case (head_cmd.op)
      OP_NONE: n_main = 3'd0;
      OP_CP:   n_main = cp_len;
      default: n_main = 3'd1;
    endcase
  end

  assign total = n_pre + n_main;
  assign j     = idx_r - n_pre;

  always_comb begin
    cp_byte = 8'h00;
    case (cp_len)
      3'd1: cp_byte = {1'b0, cp[6:0]};
      3'd2: begin
        case (j[1:0])
          2'd0:    cp_byte = {3'b110, cp[10:6]};
          default: cp_byte = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (j[1:0])
          2'd0:    cp_byte = {4'b1110, cp[15:12]};
          2'd1:    cp_byte = {2'b10, cp[11:6]};
          default: cp_byte = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (j[1:0])
          2'd0:    cp_byte = {5'b11110, cp[20:18]};
          2'd1:    cp_byte = {2'b10, cp[17:12]};
          2'd2:    cp_byte = {2'b10, cp[11:6]};
          default: cp_byte = {2'b10, cp[5:0]};
        endcase
      end
    endcase
  end

  always_comb begin
    e_byte   = 8'h00;
    e_bvalid = 1'b0;
    e_done   = 1'b0;
    e_err    = 1'b0;
    e_kind   = 3'd0;
    if (idx_r < n_pre) begin
      e_bvalid = 1'b1;
      case (idx_r[1:0])
        2'd0:    e_byte = REPL_B0;
        2'd1:    e_byte = REPL_B1;
        default: e_byte = REPL_B2;
      endcase
    end else begin
      case (head_cmd.op)
        OP_RAW: begin
          e_bvalid = 1'b1;
          e_byte   = head_cmd.data[7:0];
        end
        OP_CP: begin
          e_bvalid = 1'b1;
          e_byte   = cp_byte;
        end
        OP_DONE: e_done = 1'b1;
        OP_ERR: begin
          e_err  = 1'b1;
          e_kind = head_cmd.data[2:0];
        end
        default: e_bvalid = 1'b0;
      endcase
    end
  end

  assign e_last = (idx_r == total - 3'd1);
  assign load   = !valid_r || out_ready;
  assign pop    = load && head_valid && e_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= head_valid;
      if (head_valid) idx_r <= e_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= e_byte;
      bvalid_r <= e_bvalid;
      done_r   <= e_done;
      err_r    <= e_err;
      kind_r   <= e_kind;
      last_r   <= e_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bvalid_r;
  assign out_string_done = done_r;
  assign out_error_flag  = err_r;
  assign out_error_kind  = kind_r;
  assign out_last        = last_r;

endmodule

### rtl/json_string_unescape_utf8_unit.sv
// Top level of the streaming JSON string unescape to UTF-8 unit.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid/in_ready, in_byte, in_end_of_text | in
//   result  | out_valid/out_ready, out_byte, out_byte_valid,
//           | out_string_done, out_error_flag, out_error_kind, out_last | out
//
// One input byte is taken per cycle while the request queue has room.
// Each result item leaves the output register when out_ready takes it; an input that
// expands to n results holds the back end until all n have left, so long runs of
// multi-byte sequences throttle input through the queue (QUEUE_DEPTH deep).
// Synchronous active-low reset returns to idle, awaiting the opening quote.
// Input and output stall independently; a backed-up output stops the input
// only once the queue fills.
module json_string_unescape_utf8_unit
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_string_done,
  output logic       out_error_flag,
  output logic [2:0] out_error_kind,
  output logic       out_last
);

  logic q_full, q_push, q_pop, q_head_valid;
  cmd_t q_cmd, q_head_cmd;

  jsu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_end_of_text(in_end_of_text),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  jsu_cmdq #(
    .DEPTH(QUEUE_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_cmd  (q_head_cmd)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_cmd       (q_head_cmd),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_string_done(out_string_done),
    .out_error_flag (out_error_flag),
    .out_error_kind (out_error_kind),
    .out_last       (out_last)
  );

endmodule
